// File: rtl/core/gda_pkg.sv
// gda_pkg: types, codes and calendar helpers for the date arithmetic unit
// depends on nothing; used by every module of the block
`default_nettype none
package gda_pkg;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [15:0] day_count;
      logic [4:0]  other_day;
      logic [3:0]  other_month;
      logic [13:0] other_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  res_day;
      logic [3:0]  res_month;
      logic [13:0] res_year;
      logic        is_greater;
      logic        is_less;
      logic        is_equal;
      logic [21:0] distance;
      logic [1:0]  error;
   } rsp_type;

   localparam logic [2:0] OP_NEXT = 3'd0;
   localparam logic [2:0] OP_PREV = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_SUB  = 3'd3;
   localparam logic [2:0] OP_CMP  = 3'd4;
   localparam logic [2:0] OP_DIST = 3'd5;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_DATE  = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;

   localparam logic [21:0] LAST_DAYNUM = 22'd3652058;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;

   // datapath commands from the controller
   typedef struct packed {
      logic load;      // capture request
      logic cnv_b;     // convert both dates to day numbers
      logic arith;     // day-number arithmetic
      logic ydiv;      // year estimate from the product
      logic yfix;      // one year-correction step
      logic mstep;     // one month-walk step
      logic finish;    // assemble result
   } cmd_type;

   typedef struct packed {
      logic is_date;   // op produces a date
      logic is_pair;   // op is compare or distance
      logic bad;       // invalid input date(s)
      logic yfix_done;
      logic mstep_done;
   } sts_type;

   // divide by 100 through a reciprocal multiply, exact for any 14-bit value
   function automatic logic [13:0] div100(input logic [13:0] v);
      div100 = 14'((28'(v) * 28'd5243) >> 19);
   endfunction

   function automatic logic leap(input logic [13:0] y);
      logic [13:0] q;
      logic [13:0] r100;
      begin
         q    = div100(y);
         r100 = y - q * 14'd100;
         leap = (y[1:0] == 2'b00) && ((r100 != 14'd0) || (q[1:0] == 2'b00));
      end
   endfunction

   function automatic logic [4:0] mlen(input logic [3:0] m, input logic ly);
      case (m)
         4'd2:                      mlen = ly ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
         default:                   mlen = 5'd31;
      endcase
   endfunction

   // days in months before month m (1..12)
   function automatic logic [8:0] cum(input logic [3:0] m, input logic ly);
      logic [8:0] c;
      begin
         case (m)
            4'd1:  c = 9'd0;
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            default: c = 9'd334;
         endcase
         cum = (ly && (m > 4'd2)) ? c + 9'd1 : c;
      end
   endfunction

   // days from 0001-01-01 to Jan 1 of year y
   function automatic logic [21:0] dby(input logic [13:0] y);
      logic [13:0] p;
      logic [13:0] c;
      begin
         p   = y - 14'd1;
         c   = div100(p);
         dby = 22'(p) * 22'd365 + 22'(p >> 2) - 22'(c) + 22'(c >> 2);
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/gda_datapath.sv
// gda_datapath: date validation, day-number conversion, arithmetic and conversion back
// depends on gda_pkg
`default_nettype none
module gda_datapath import gda_pkg::*; (
   input  wire logic    clock,
   input  wire req_type req,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp
);

   req_type     r_ff;
   logic [21:0] na_ff, na_in;
   logic [21:0] nb_ff;
   logic [21:0] n_ff, n_in;
   logic [1:0]  err_ff, err_in;
   logic [13:0] yy_ff, yy_in;
   logic [3:0]  mm_ff, mm_in;
   logic [35:0] prod_ff;
   logic        va, vb;
   logic        lya, lyb, lyy;

   // validity and conversion
   assign lya = leap(r_ff.year);
   assign lyb = leap(r_ff.other_year);
   assign lyy = leap(yy_ff);
   assign va = (r_ff.year >= 14'd1) && (r_ff.year <= YEAR_MAX) && (r_ff.month >= 4'd1)
               && (r_ff.month <= 4'd12) && (r_ff.day >= 5'd1)
               && (r_ff.day <= mlen(r_ff.month, lya));
   assign vb = (r_ff.other_year >= 14'd1) && (r_ff.other_year <= YEAR_MAX)
               && (r_ff.other_month >= 4'd1) && (r_ff.other_month <= 4'd12)
               && (r_ff.other_day >= 5'd1)
               && (r_ff.other_day <= mlen(r_ff.other_month, lyb));

   assign sts.is_date    = (r_ff.req_type <= OP_SUB);
   assign sts.is_pair    = (r_ff.req_type == OP_CMP) || (r_ff.req_type == OP_DIST);
   assign sts.bad        = !va || (sts.is_pair && !vb);
   assign sts.yfix_done  = !(((yy_ff > 14'd1) && (dby(yy_ff) > n_ff))
                            || ((yy_ff < YEAR_MAX) && (dby(yy_ff + 14'd1) <= n_ff)));
   assign sts.mstep_done = (mm_ff == 4'd12) || (n_ff < 22'(mlen(mm_ff, lyy)));

   // arithmetic on day numbers
   always_comb begin
      logic [21:0] delta;
      na_in  = na_ff;
      n_in   = n_ff;
      err_in = err_ff;
      yy_in  = yy_ff;
      mm_in  = mm_ff;
      delta  = (r_ff.req_type == OP_NEXT || r_ff.req_type == OP_PREV) ? 22'd1
               : 22'(r_ff.day_count);
      if (cmd.load) begin
         err_in = ERR_NONE;
      end
      if (cmd.cnv_b) begin
         na_in = dby(r_ff.year) + 22'(cum(r_ff.month, lya)) + 22'(r_ff.day) - 22'd1;
      end
      if (cmd.arith) begin
         if (r_ff.req_type == OP_NEXT || r_ff.req_type == OP_ADD) begin
            if (delta > LAST_DAYNUM - na_ff) begin
               n_in = LAST_DAYNUM; err_in = ERR_RANGE;
            end else begin
               n_in = na_ff + delta;
            end
         end else begin
            if (delta > na_ff) begin
               n_in = 22'd0; err_in = ERR_RANGE;
            end else begin
               n_in = na_ff - delta;
            end
         end
      end
      if (cmd.ydiv) begin
         yy_in = (prod_ff[35:22] >= YEAR_MAX) ? YEAR_MAX : prod_ff[35:22] + 14'd1;
         mm_in = 4'd1;
      end
      if (cmd.yfix) begin
         if ((yy_ff > 14'd1) && (dby(yy_ff) > n_ff)) begin
            yy_in = yy_ff - 14'd1;
         end else if ((yy_ff < YEAR_MAX) && (dby(yy_ff + 14'd1) <= n_ff)) begin
            yy_in = yy_ff + 14'd1;
         end else begin
            n_in = n_ff - dby(yy_ff);
         end
      end
      if (cmd.mstep) begin
         n_in  = n_ff - 22'(mlen(mm_ff, lyy));
         mm_in = mm_ff + 4'd1;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (cmd.cnv_b) nb_ff <= dby(r_ff.other_year) + 22'(cum(r_ff.other_month, lyb))
                               + 22'(r_ff.other_day) - 22'd1;
      // n*400/146097 ~ n*11484 >> 22, corrected afterwards by year walk
      prod_ff <= 36'(n_ff) * 36'd11484;
      na_ff  <= na_in;
      n_ff   <= n_in;
      err_ff <= err_in;
      yy_ff  <= yy_in;
      mm_ff  <= mm_in;
   end

   // result assembly
   always_comb begin
      rsp = '0;
      if (sts.is_date || sts.is_pair) begin
         if (sts.bad) begin
            rsp.error = ERR_DATE;
         end else if (sts.is_date) begin
            rsp.res_day   = 5'(n_ff) + 5'd1;
            rsp.res_month = mm_ff;
            rsp.res_year  = yy_ff;
            rsp.error     = err_ff;
         end else if (r_ff.req_type == OP_CMP) begin
            rsp.is_greater = na_ff > nb_ff;
            rsp.is_less    = na_ff < nb_ff;
            rsp.is_equal   = na_ff == nb_ff;
         end else begin
            rsp.distance = (na_ff > nb_ff) ? na_ff - nb_ff : nb_ff - na_ff;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/gda_ctrl.sv
// gda_ctrl: sequencer for the date arithmetic unit
// depends on gda_pkg
`default_nettype none
module gda_ctrl import gda_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         rsp_load
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CNV  = 4'd1;
   localparam logic [3:0] S_ARI  = 4'd2;
   localparam logic [3:0] S_MUL  = 4'd3;
   localparam logic [3:0] S_MUL2 = 4'd4;
   localparam logic [3:0] S_YFIX = 4'd5;
   localparam logic [3:0] S_MON  = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       full_ff, full_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = full_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; state_in = S_CNV;
         end
         S_CNV: begin
            cmd.cnv_b = 1'b1; state_in = S_ARI;
         end
         S_ARI: begin
            if (sts.is_date && !sts.bad) begin
               cmd.arith = 1'b1; state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL:  state_in = S_MUL2;
         S_MUL2: begin
            cmd.ydiv = 1'b1; state_in = S_YFIX;
         end
         S_YFIX: begin
            cmd.yfix = 1'b1;
            if (sts.yfix_done) state_in = S_MON;
         end
         S_MON: begin
            if (sts.mstep_done) state_in = S_DONE;
            else cmd.mstep = 1'b1;
         end
         S_DONE: if (!full_ff) begin
            rsp_load = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat holding
   always_comb begin
      full_in = full_ff;
      if (rsp_ready) full_in = 1'b0;
      if (rsp_load)  full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/gregorian_date_arithmetic.sv
// gregorian_date_arithmetic: top level of the date arithmetic unit
// depends on gda_pkg, gda_ctrl, gda_datapath
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one request beat: an
//   operation code and one or two dates. rsp channel (rsp_valid/rsp_ready/
//   rsp_data) returns exactly one result beat per request.
//   One request is processed at a time. After the request beat the sequencer
//   passes through CNV and ARI; date operations on valid dates go on through
//   MUL, MUL2, the year-correction steps in YFIX and one month-walk step per
//   month walked (up to 11) in MON; compare, distance, invalid dates and
//   unused codes go from ARI straight to DONE. req_ready returns the cycle
//   after the result is loaded in DONE.
//   The result sits in an output register; the next request is taken while
//   it waits, and a stalled receiver holds the result and, once the next
//   one is finished, holds the request side too.
//   Synchronous reset empties the output register and returns the
//   sequencer to idle.
`default_nettype none
module gregorian_date_arithmetic import gda_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;
   rsp_type res;
   logic    rsp_load;
   rsp_type out_ff;

   gda_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd, .rsp_load
   );

   gda_datapath u_dp (
      .clock, .req(req_data), .cmd, .sts, .rsp(res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) out_ff <= res;
   end
   assign rsp_data = out_ff;

endmodule
`default_nettype wire

// File: tb/gregorian_date_arithmetic_tb.sv
// gregorian_date_arithmetic_tb: self-checking bench for the date arithmetic unit
// depends on gda_pkg and gregorian_date_arithmetic; directed table, then random beats
`default_nettype none
module gregorian_date_arithmetic_tb import gda_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_BEATS   = 1900;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   gregorian_date_arithmetic uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rsp_type pending_dates[$];
   int      mismatch_count = 0;
   int      sent_beats = 0;
   int      got_beats = 0;
   int      idle_cycles = 0;
   bit      calm_mode = 1'b0;
   bit      hold_rsp = 1'b0;
   bit      stim_done = 1'b0;
   int      op_seen[8];
   int      err_seen[4];

   // calendar helpers for the predictor
   function automatic bit is_leap(int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic int unsigned month_days(int unsigned m, int unsigned y);
      int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && is_leap(y)) return 29;
      return lens[(m - 1) % 12];
   endfunction

   function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= month_days(m, y);
   endfunction

   function automatic int unsigned year_start(int unsigned y);
      int unsigned p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic int unsigned day_index(int unsigned d, int unsigned m,
                                             int unsigned y);
      int unsigned n;
      n = year_start(y);
      for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
      return n + d - 1;
   endfunction

   // turn a day index back into a calendar date
   function automatic void index_to_date(int unsigned n, output int unsigned d,
                                         output int unsigned m, output int unsigned y);
      longint unsigned est;
      est = (longint'(n) * 400) / 146097 + 1;
      y = (est > 9999) ? 9999 : 32'(est);
      while (y > 1 && year_start(y) > n) y--;
      while (y < 9999 && year_start(y + 1) <= n) y++;
      n -= year_start(y);
      m = 1;
      while (m < 12 && n >= month_days(m, y)) begin
         n -= month_days(m, y);
         m++;
      end
      d = n + 1;
   endfunction

   function automatic rsp_type predict_date_result(req_type r);
      rsp_type     o;
      int unsigned n, a, b, delta, d, m, y;
      int unsigned d1, m1, y1, d2, m2, y2, last;
      o = '0;
      d1 = 32'(r.day); m1 = 32'(r.month); y1 = 32'(r.year);
      d2 = 32'(r.other_day); m2 = 32'(r.other_month); y2 = 32'(r.other_year);
      last = 32'(LAST_DAYNUM);
      if (r.req_type <= OP_SUB) begin
         if (!date_ok(d1, m1, y1)) begin
            o.error = ERR_DATE;
         end else begin
            n = day_index(d1, m1, y1);
            delta = (r.req_type == OP_NEXT || r.req_type == OP_PREV) ? 1
                    : 32'(r.day_count);
            if (r.req_type == OP_NEXT || r.req_type == OP_ADD) begin
               if (delta > last - n) begin
                  n = last;
                  o.error = ERR_RANGE;
               end else n += delta;
            end else begin
               if (delta > n) begin
                  n = 0;
                  o.error = ERR_RANGE;
               end else n -= delta;
            end
            index_to_date(n, d, m, y);
            o.res_day = 5'(d);
            o.res_month = 4'(m);
            o.res_year = 14'(y);
         end
      end else if (r.req_type <= OP_DIST) begin
         if (!date_ok(d1, m1, y1) || !date_ok(d2, m2, y2)) begin
            o.error = ERR_DATE;
         end else begin
            a = day_index(d1, m1, y1);
            b = day_index(d2, m2, y2);
            if (r.req_type == OP_CMP) begin
               o.is_greater = a > b;
               o.is_less = a < b;
               o.is_equal = a == b;
            end else o.distance = 22'((a > b) ? a - b : b - a);
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at beat %0d: %s got %0d expected %0d", got_beats, what, got, want);
      mismatch_count++;
   endtask

   // directed table: fixed expectation where it is obvious, else predictor
   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type want;
   } dir_row_type;

   function automatic req_type mk(logic [2:0] op, int d, int m, int y, int c,
                                  int d2, int m2, int y2);
      req_type r;
      r.req_type = op; r.day = 5'(d); r.month = 4'(m); r.year = 14'(y);
      r.day_count = 16'(c);
      r.other_day = 5'(d2); r.other_month = 4'(m2); r.other_year = 14'(y2);
      return r;
   endfunction

   function automatic rsp_type dt(int d, int m, int y, logic [1:0] e);
      rsp_type o;
      o = '0; o.res_day = 5'(d); o.res_month = 4'(m); o.res_year = 14'(y); o.error = e;
      return o;
   endfunction

   function automatic rsp_type er(logic [1:0] e);
      rsp_type o;
      o = '0; o.error = e;
      return o;
   endfunction

   dir_row_type dir_rows[$];

   initial begin
      dir_rows.push_back('{mk(OP_NEXT, 31, 12, 9999, 0, 0, 0, 0), 1,
                           dt(31, 12, 9999, ERR_RANGE)});
      dir_rows.push_back('{mk(OP_PREV, 1, 1, 1, 0, 0, 0, 0), 1, dt(1, 1, 1, ERR_RANGE)});
      dir_rows.push_back('{mk(OP_NEXT, 28, 2, 2000, 0, 0, 0, 0), 1, dt(29, 2, 2000, ERR_NONE)});
      dir_rows.push_back('{mk(OP_NEXT, 28, 2, 1900, 0, 0, 0, 0), 1, dt(1, 3, 1900, ERR_NONE)});
      dir_rows.push_back('{mk(OP_NEXT, 29, 2, 1900, 0, 0, 0, 0), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(OP_PREV, 1, 3, 2024, 0, 0, 0, 0), 1, dt(29, 2, 2024, ERR_NONE)});
      dir_rows.push_back('{mk(OP_NEXT, 0, 5, 2020, 0, 0, 0, 0), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(OP_NEXT, 31, 15, 16383, 0, 0, 0, 0), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(OP_PREV, 1, 1, 0, 0, 0, 0, 0), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(OP_ADD, 1, 1, 1, 65535, 0, 0, 0), 0, '0});
      dir_rows.push_back('{mk(OP_ADD, 1, 1, 9999, 65535, 0, 0, 0), 1,
                           dt(31, 12, 9999, ERR_RANGE)});
      dir_rows.push_back('{mk(OP_ADD, 15, 6, 2000, 0, 0, 0, 0), 1, dt(15, 6, 2000, ERR_NONE)});
      dir_rows.push_back('{mk(OP_SUB, 31, 12, 9999, 65535, 0, 0, 0), 0, '0});
      dir_rows.push_back('{mk(OP_SUB, 5, 3, 1, 65535, 0, 0, 0), 1, dt(1, 1, 1, ERR_RANGE)});
      dir_rows.push_back('{mk(OP_CMP, 1, 1, 1, 0, 31, 12, 9999), 1,
                           '{default: '0, is_less: 1'b1}});
      dir_rows.push_back('{mk(OP_CMP, 31, 12, 9999, 0, 1, 1, 1), 1,
                           '{default: '0, is_greater: 1'b1}});
      dir_rows.push_back('{mk(OP_CMP, 7, 7, 777, 0, 7, 7, 777), 1,
                           '{default: '0, is_equal: 1'b1}});
      dir_rows.push_back('{mk(OP_CMP, 7, 7, 777, 0, 31, 4, 777), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(OP_DIST, 1, 1, 1, 0, 31, 12, 9999), 1,
                           '{default: '0, distance: LAST_DAYNUM}});
      dir_rows.push_back('{mk(OP_DIST, 31, 12, 9999, 0, 1, 1, 1), 0, '0});
      dir_rows.push_back('{mk(OP_DIST, 30, 2, 2000, 0, 1, 1, 1), 1, er(ERR_DATE)});
      dir_rows.push_back('{mk(3'd6, 31, 15, 16383, 65535, 31, 15, 16383), 1, '0});
      dir_rows.push_back('{mk(3'd7, 1, 1, 2000, 1, 1, 1, 2000), 1, '0});
   end

   // random request: mostly valid dates, some broken fields
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r = '0;
      pick = $urandom_range(0, 99);
      r.req_type = 3'((pick < 3) ? $urandom_range(6, 7) : $urandom_range(0, 5));
      r.year = 14'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 9998 + 1
                                              : $urandom_range(1, 9999));
      r.month = 4'($urandom_range(1, 12));
      r.day = 5'($urandom_range(1, month_days(32'(r.month), 32'(r.year))));
      r.other_year = ($urandom_range(0, 3) == 0) ? r.year : 14'($urandom_range(1, 9999));
      r.other_month = 4'($urandom_range(1, 12));
      r.other_day = 5'($urandom_range(1, month_days(32'(r.other_month),
                                                    32'(r.other_year))));
      if ($urandom_range(0, 4) == 0) begin
         r.other_year = r.year; r.other_month = r.month; r.other_day = r.day;
      end
      r.day_count = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400));
      // noise: raw field values
      if ($urandom_range(0, 9) == 0) begin
         r.day = 5'($urandom); r.month = 4'($urandom); r.year = 14'($urandom);
      end
      if ($urandom_range(0, 14) == 0) begin
         r.other_day = 5'($urandom); r.other_month = 4'($urandom);
         r.other_year = 14'($urandom);
      end
      if ($urandom_range(0, 14) == 0) begin
         r.month = 4'd2; r.day = 5'd29;
      end
      return r;
   endfunction

   // offer one beat from a falling edge, return at the falling edge after accept
   task automatic send_beat(req_type r);
      while (!calm_mode && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      op_seen[r.req_type]++;
      sent_beats++;
      @(negedge clock);
   endtask

   // sender
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         pending_dates.push_back(dir_rows[i].fixed ? dir_rows[i].want
                                                   : predict_date_result(dir_rows[i].r));
         send_beat(dir_rows[i].r);
      end
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         req_type r;
         r = random_request();
         calm_mode = (i >= 600 && i < 800);
         if (i == 300) hold_rsp = 1'b1;
         if (i == 1000) begin
            // drain everything before going on
            req_valid <= 1'b0;
            do @(negedge clock); while (pending_dates.size() != 0);
         end
         pending_dates.push_back(predict_date_result(r));
         send_beat(r);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (hold_rsp);
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // receiver ready
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= calm_mode || ($urandom_range(0, 99) >= 34);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type want;
         if (pending_dates.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_data.res_day !== want.res_day)
               report_mismatch("res_day", 32'(rsp_data.res_day), 32'(want.res_day));
            if (rsp_data.res_month !== want.res_month)
               report_mismatch("res_month", 32'(rsp_data.res_month), 32'(want.res_month));
            if (rsp_data.res_year !== want.res_year)
               report_mismatch("res_year", 32'(rsp_data.res_year), 32'(want.res_year));
            if (rsp_data.is_greater !== want.is_greater)
               report_mismatch("is_greater", 32'(rsp_data.is_greater),
                               32'(want.is_greater));
            if (rsp_data.is_less !== want.is_less)
               report_mismatch("is_less", 32'(rsp_data.is_less), 32'(want.is_less));
            if (rsp_data.is_equal !== want.is_equal)
               report_mismatch("is_equal", 32'(rsp_data.is_equal), 32'(want.is_equal));
            if (rsp_data.distance !== want.distance)
               report_mismatch("distance", 32'(rsp_data.distance), 32'(want.distance));
            if (rsp_data.error !== want.error)
               report_mismatch("error", 32'(rsp_data.error), 32'(want.error));
            err_seen[want.error]++;
         end
         got_beats++;
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_dates.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d requests, next/prev/add/sub/cmp/dist/unused: %0d %0d %0d %0d",
               sent_beats, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("   %0d %0d %0d; results ok/bad date/saturated: %0d %0d %0d, mismatches %0d",
               op_seen[4], op_seen[5], op_seen[6] + op_seen[7],
               err_seen[0], err_seen[1], err_seen[2], mismatch_count);
      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
